@@ rtl/var128_token_decoder_unit_defines.svh @@
// Assertion macros shared by the token decoder RTL.
// Included by the top level; depends on nothing else.
`ifndef VAR128_TOKEN_DECODER_UNIT_DEFINES_SVH
`define VAR128_TOKEN_DECODER_UNIT_DEFINES_SVH

`define VTD_ASSERT_NOW(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("token decoder assertion failed");

`define VTD_ASSERT_NEXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("token decoder assertion failed");

`endif

@@ rtl/vtd_pkg.sv @@
// Types, codes and helper functions of the token decoder.
// Used by the top level; depends on nothing.
`default_nettype none

package vtd_pkg;

  localparam int unsigned MAX_PAYLOAD_BYTES = 8;

  typedef enum logic [1:0] {
    KIND_RAW      = 2'd0,
    KIND_UNSIGNED = 2'd1,
    KIND_SIGNED   = 2'd2,
    KIND_DOUBLE   = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ST_VALUE         = 3'd0,
    ST_CONTROL       = 3'd1,
    ST_BAD_BYTE      = 3'd2,
    ST_TOO_LONG      = 3'd3,
    ST_UNEXP_CONTROL = 3'd4,
    ST_NEED_MORE     = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    CTL_NONE = 2'd0,
    CTL_E0   = 2'd1,
    CTL_E1   = 2'd2
  } ctl_t;

  localparam logic [7:0] BYTE_CTRL_E0 = 8'he0;
  localparam logic [7:0] BYTE_CTRL_E1 = 8'he1;
  localparam logic [3:0] NIBBLE_LEN   = 4'hf;

  function automatic logic [63:0] apply_kind(kind_t k, logic [63:0] v);
    logic [63:0] r;
    begin
      r = v;
      case (k)
        KIND_SIGNED: begin
          r = v[0] ? ~(v >> 1) : (v >> 1);
        end
        KIND_DOUBLE: begin
          for (int i = 0; i < 8; i++) begin
            r[8*i +: 8] = v[56 - 8*i +: 8];
          end
        end
        default: begin
          r = v;
        end
      endcase
      return r;
    end
  endfunction

endpackage

`default_nettype wire

@@ rtl/vtd_in_if.sv @@
// Byte stream channel of the token decoder: valid, ready and one byte with its kind.
// Depends on nothing.
`default_nettype none

interface vtd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic [1:0] opcode;
  logic       stream_end;

  modport source (output valid, output data_byte, output opcode, output stream_end,
                  input ready);
  modport sink (input valid, input data_byte, input opcode, input stream_end,
                output ready);
endinterface

`default_nettype wire

@@ rtl/vtd_out_if.sv @@
// Result channel of the token decoder: valid, ready, status, value and control code.
// Depends on nothing.
`default_nettype none

interface vtd_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [63:0] value;
  logic [1:0]  control_code;

  modport source (output valid, output status, output value, output control_code,
                  input ready);
  modport sink (input valid, input status, input value, input control_code,
                output ready);
endinterface

`default_nettype wire

@@ rtl/var128_token_decoder_unit.sv @@
// Top level of the length-prefixed varint token decoder.
// Depends on vtd_pkg, vtd_in_if, vtd_out_if and the assertion macro header.
//
// Channel  Direction  Transaction
// stream   sink       one byte of the encoded stream, its kind and an end flag
// result   source     status, 64-bit value and control code of one token event
//
// One byte per cycle is sustained while the result is not stalled; a byte is held in the
// input register and its result, if any, is then registered in the output register.
// The decode path between the two registers is a shift of the accumulator and a
// kind mapping. Reset clears the token state and both valid flags.
// A stalled result holds the input register, which then blocks new bytes.
`default_nettype none
`include "var128_token_decoder_unit_defines.svh"

module var128_token_decoder_unit (
  input  wire logic   clk,
  input  wire logic   rst,
  vtd_in_if.sink      stream,
  vtd_out_if.source   result
);

  logic                s1_valid;
  logic [7:0]          s1_byte;
  vtd_pkg::kind_t      s1_kind;
  logic                s1_end;
  logic                s1_go;

  logic                in_token;
  logic [3:0]          bytes_left;
  logic [63:0]         accumulator;
  vtd_pkg::kind_t      latched_kind;

  logic                in_token_next;
  logic [3:0]          bytes_left_next;
  logic [63:0]         accumulator_next;
  vtd_pkg::kind_t      latched_kind_next;

  logic                emit;
  vtd_pkg::status_t    emit_status;
  logic [63:0]         emit_value;
  vtd_pkg::ctl_t       emit_ctl;

  logic [3:0]          left_dec;
  logic [63:0]         acc_shift;
  logic [4:0]          announced_len;

  logic                o_valid;
  vtd_pkg::status_t    o_status;
  logic [63:0]         o_value;
  vtd_pkg::ctl_t       o_ctl;

  assign s1_go        = s1_valid && (!o_valid || result.ready);
  assign stream.ready = !s1_valid || s1_go;

  assign left_dec      = bytes_left - 4'd1;
  assign acc_shift     = {accumulator[55:0], s1_byte};
  assign announced_len = 5'd16 - {1'b0, s1_byte[3:0]};

  always_comb begin
    in_token_next     = in_token;
    bytes_left_next   = bytes_left;
    accumulator_next  = accumulator;
    latched_kind_next = latched_kind;
    emit              = 1'b0;
    emit_status       = vtd_pkg::ST_VALUE;
    emit_value        = 64'd0;
    emit_ctl          = vtd_pkg::CTL_NONE;
    if (in_token) begin
      accumulator_next = acc_shift;
      bytes_left_next  = left_dec;
      if (left_dec == 4'd0) begin
        in_token_next = 1'b0;
        emit          = 1'b1;
        emit_value    = vtd_pkg::apply_kind(latched_kind, acc_shift);
      end else if (s1_end) begin
        emit        = 1'b1;
        emit_status = vtd_pkg::ST_NEED_MORE;
      end
    end else if (!s1_byte[7]) begin
      emit       = 1'b1;
      emit_value = vtd_pkg::apply_kind(s1_kind, {56'd0, s1_byte});
    end else if (s1_byte[7:4] == vtd_pkg::NIBBLE_LEN) begin
      if (announced_len > 5'(vtd_pkg::MAX_PAYLOAD_BYTES)) begin
        emit        = 1'b1;
        emit_status = vtd_pkg::ST_TOO_LONG;
      end else begin
        in_token_next     = 1'b1;
        bytes_left_next   = announced_len[3:0];
        accumulator_next  = 64'd0;
        latched_kind_next = s1_kind;
        if (s1_end) begin
          emit        = 1'b1;
          emit_status = vtd_pkg::ST_NEED_MORE;
        end
      end
    end else if (s1_byte == vtd_pkg::BYTE_CTRL_E0 || s1_byte == vtd_pkg::BYTE_CTRL_E1) begin
      emit        = 1'b1;
      emit_ctl    = (s1_byte == vtd_pkg::BYTE_CTRL_E0) ? vtd_pkg::CTL_E0 : vtd_pkg::CTL_E1;
      emit_status = (s1_kind == vtd_pkg::KIND_RAW) ? vtd_pkg::ST_CONTROL
                                                   : vtd_pkg::ST_UNEXP_CONTROL;
    end else begin
      emit        = 1'b1;
      emit_status = vtd_pkg::ST_BAD_BYTE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (stream.ready) begin
      s1_valid <= stream.valid;
    end
    if (stream.valid && stream.ready) begin
      s1_byte <= stream.data_byte;
      s1_kind <= vtd_pkg::kind_t'(stream.opcode);
      s1_end  <= stream.stream_end;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_token     <= 1'b0;
      bytes_left   <= 4'd0;
      accumulator  <= 64'd0;
      latched_kind <= vtd_pkg::KIND_RAW;
    end else if (s1_go) begin
      in_token     <= in_token_next;
      bytes_left   <= bytes_left_next;
      accumulator  <= accumulator_next;
      latched_kind <= latched_kind_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (s1_go) begin
      o_valid <= emit;
    end else if (result.ready) begin
      o_valid <= 1'b0;
    end
    if (s1_go && emit) begin
      o_status <= emit_status;
      o_value  <= emit_value;
      o_ctl    <= emit_ctl;
    end
  end

  assign result.valid        = o_valid;
  assign result.status       = o_status;
  assign result.value        = o_value;
  assign result.control_code = o_ctl;

  `VTD_ASSERT_NOW(a_value_zero_on_status, clk, rst,
    o_valid && o_status != vtd_pkg::ST_VALUE, o_value == 64'd0)
  `VTD_ASSERT_NOW(a_ctl_only_on_control, clk, rst,
    o_valid && o_status != vtd_pkg::ST_CONTROL && o_status != vtd_pkg::ST_UNEXP_CONTROL,
    o_ctl == vtd_pkg::CTL_NONE)
  `VTD_ASSERT_NOW(a_token_has_bytes, clk, rst,
    in_token,
    bytes_left != 4'd0 && bytes_left <= 4'(vtd_pkg::MAX_PAYLOAD_BYTES))
  `VTD_ASSERT_NEXT(a_accept_loads_stage, clk, rst,
    stream.valid && stream.ready, s1_valid)

endmodule

`default_nettype wire
